// ===== design/rcd_pkg.sv =====
// Shared constants and types for the Rice code decoder.
package rcd_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int DATA_W        = 32;
  localparam int K_W           = 5;
  localparam int MAX_RESULTS   = 32;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic              start;
    logic              valid;
    logic              data;
    logic              last;
  } scan_bit_t;

  typedef struct packed {
    logic              fire;
    logic [DATA_W-1:0] value;
    logic              sat;
  } dec_ev_t;

  typedef struct packed {
    logic [DATA_W-1:0] decoded_value;
    logic              saturated;
    logic              last_of_word;
  } result_t;

endpackage

// ===== design/rcd_ifs.sv =====
// Channel interfaces for the Rice code decoder: stream words, results, configuration.
interface rcd_stream_if import rcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] stream_word;

  modport source(output valid, output stream_word, input ready);
  modport sink(input valid, input stream_word, output ready);
endinterface

interface rcd_result_if import rcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] decoded_value;
  logic              saturated;
  logic              last_of_word;

  modport source(output valid, output decoded_value, output saturated, output last_of_word,
                 input ready);
  modport sink(input valid, input decoded_value, input saturated, input last_of_word,
               output ready);
endinterface

interface rcd_cfg_if import rcd_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [K_W-1:0] low_bit_count;

  modport source(output valid, output low_bit_count, input ready);
  modport sink(input valid, input low_bit_count, output ready);
endinterface

// ===== design/rcd_scan.sv =====
// Word shift register: loads a stream word and presents its bits one per cycle while step is high, MSB first.
module rcd_scan import rcd_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_word,
  input  logic              hold,
  input  logic              step,
  output scan_bit_t         sb
);

  localparam int IDX_W = $clog2(WORD_BITS);

  logic                        busy_r, busy_nxt;
  logic [WORD_BITS-1:0]        sr_r, sr_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [WORD_BITS+DATA_W-1:0] word_ext;
  logic                        accept;

  assign word_ext = {{WORD_BITS{1'b0}}, in_word};
  assign in_ready = !busy_r && !hold;
  assign accept   = in_valid && in_ready;

  assign sb.start = accept;
  assign sb.valid = busy_r;
  assign sb.data  = sr_r[WORD_BITS-1];
  assign sb.last  = (idx_r == '0);

  always_comb begin
    busy_nxt = busy_r;
    sr_nxt   = sr_r;
    idx_nxt  = idx_r;
    if (accept) begin
      busy_nxt = 1'b1;
      sr_nxt   = word_ext[WORD_BITS-1:0];
      idx_nxt  = IDX_W'(WORD_BITS - 1);
    end else if (step) begin
      sr_nxt  = {sr_r[WORD_BITS-2:0], 1'b0};
      idx_nxt = idx_r - 1'b1;
      if (sb.last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    sr_r <= sr_nxt;
  end

endmodule

// ===== design/rcd_bitdec.sv =====
// Bit-serial Rice decoder state: counts the unary prefix and shifts in the low bits.
module rcd_bitdec import rcd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [K_W-1:0] k,
  input  scan_bit_t      sb,
  input  logic           step,
  output dec_ev_t        ev
);

  logic [DATA_W-1:0] prefix_r, prefix_nxt;
  logic              in_low_r, in_low_nxt;
  logic [K_W-1:0]    left_r, left_nxt;
  logic [DATA_W-1:0] part_r, part_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DATA_W-1:0] val;
  logic              ovf_eff;
  logic              b_in;

  assign b_in = sb.data;

  always_comb begin
    prefix_nxt = prefix_r;
    in_low_nxt = in_low_r;
    left_nxt   = left_r;
    part_nxt   = part_r;
    ovf_nxt    = ovf_r;
    val        = part_r;
    ovf_eff    = ovf_r;
    ev.fire    = 1'b0;
    if (sb.valid) begin
      if (!in_low_r) begin
        if (!b_in) begin
          if (prefix_r == '1) begin
            ovf_nxt = 1'b1;
          end else begin
            prefix_nxt = prefix_r + 1'b1;
          end
        end else if (k == '0) begin
          ev.fire = 1'b1;
          val     = prefix_r;
        end else begin
          in_low_nxt = 1'b1;
          left_nxt   = k;
          part_nxt   = prefix_r;
        end
      end else if (left_r == '0) begin
        ev.fire = 1'b1;
      end else begin
        ovf_nxt  = ovf_r | part_r[DATA_W-1];
        part_nxt = {part_r[DATA_W-2:0], b_in};
        left_nxt = left_r - 1'b1;
        if (left_r == K_W'(1)) begin
          ev.fire = 1'b1;
          val     = part_nxt;
          ovf_eff = ovf_nxt;
        end
      end
    end
    if (ev.fire) begin
      prefix_nxt = '0;
      in_low_nxt = 1'b0;
      left_nxt   = '0;
      part_nxt   = '0;
      ovf_nxt    = 1'b0;
    end
    ev.value = ovf_eff ? '1 : val;
    ev.sat   = ovf_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      in_low_r <= 1'b0;
      left_r   <= '0;
      part_r   <= '0;
      ovf_r    <= 1'b0;
    end else if (step) begin
      prefix_r <= prefix_nxt;
      in_low_r <= in_low_nxt;
      left_r   <= left_nxt;
      part_r   <= part_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

// ===== design/rcd_emit.sv =====
// Result staging: holds the newest value of a word until its successor or the word end marks it.
module rcd_emit import rcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_bit_t sb,
  input  dec_ev_t   ev,
  output logic      step,
  output logic      pend_busy,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_item
);

  result_t          pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  result_t          out_r, out_nxt;
  logic             out_v_r, out_v_nxt;
  logic             out_free;
  logic             keep;
  logic             flush;

  assign out_free  = !out_v_r || out_ready;
  assign keep      = ev.fire && (cnt_r < CNT_W'(MAX_RESULTS));
  assign step      = sb.valid && !(keep && pend_v_r && !out_free);
  assign flush     = !sb.valid && pend_v_r && out_free;
  assign pend_busy = pend_v_r;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_comb begin
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    cnt_nxt    = cnt_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_ready;
    if (sb.start) begin
      cnt_nxt = '0;
    end
    if (step && keep) begin
      if (pend_v_r) begin
        out_nxt   = pend_r;
        out_v_nxt = 1'b1;
      end
      pend_nxt.decoded_value = ev.value;
      pend_nxt.saturated     = ev.sat;
      pend_nxt.last_of_word  = 1'b0;
      pend_v_nxt             = 1'b1;
      cnt_nxt                = cnt_r + 1'b1;
    end
    if (flush) begin
      out_nxt              = pend_r;
      out_nxt.last_of_word = 1'b1;
      out_v_nxt            = 1'b1;
      pend_v_nxt           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      cnt_r    <= cnt_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== design/rice_code_decoder_top.sv =====
// Rice code decoder top level: stream words in, decoded values out.
// Each accepted word is shifted through the decoder one bit per cycle, most significant
// bit first, unless the result channel stalls; after its bits, the word's final value, if it
// produced any, is released and carries last_of_word. A new word is taken only once its
// predecessor's bits and final value are through. Shifting is done by the word shift register
// and the bit-serial decode state behind it. Codes may cross word boundaries. Values
// that need more than 32 bits come out as all ones with saturated set. low_bit_count is
// written through the configuration channel, which is always ready; the user writes it only
// while the block is idle, which the block itself does not enforce.
module rice_code_decoder_top import rcd_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  rcd_stream_if.sink    in_ch,
  rcd_result_if.source  out_ch,
  rcd_cfg_if.sink       cfg_ch
);

  logic [K_W-1:0] k_r, k_nxt;
  scan_bit_t      sb;
  dec_ev_t        ev;
  logic           step;
  logic           pend_busy;
  result_t        out_item;

  assign cfg_ch.ready = 1'b1;
  assign k_nxt        = cfg_ch.valid ? cfg_ch.low_bit_count : k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      k_r <= k_nxt;
    end
  end

  rcd_scan #(
    .WORD_BITS(WORD_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_word (in_ch.stream_word),
    .hold    (pend_busy),
    .step    (step),
    .sb      (sb)
  );

  rcd_bitdec u_bitdec (
    .clk  (clk),
    .rst_n(rst_n),
    .k    (k_r),
    .sb   (sb),
    .step (step),
    .ev   (ev)
  );

  rcd_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .sb       (sb),
    .ev       (ev),
    .step     (step),
    .pend_busy(pend_busy),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_item (out_item)
  );

  assign out_ch.decoded_value = out_item.decoded_value;
  assign out_ch.saturated     = out_item.saturated;
  assign out_ch.last_of_word  = out_item.last_of_word;

endmodule

// ===== design/rcd_checker.sv =====
// Port-level checks for the Rice code decoder, bound to the top level.
module rcd_checker import rcd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_decoded_value,
  input logic              out_saturated,
  input logic              out_last_of_word
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_decoded_value)
      && $stable(out_saturated) && $stable(out_last_of_word))
    else $error("stalled result changed");

  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_decoded_value == '1)
    else $error("saturated result is not all ones");

endmodule

bind rice_code_decoder_top rcd_checker u_rcd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_decoded_value(out_ch.decoded_value),
  .out_saturated    (out_ch.saturated),
  .out_last_of_word (out_ch.last_of_word)
);
